FILE: src/amsm_pkg.sv
// Shared types and constants for the automaton string matcher.
// No dependencies; imported by every module of the block.
package amsm_pkg;

    localparam int MAX_PATTERN_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;
    localparam int LENGTH_REG_BITS   = 5;
    localparam int BYTES_REG_BITS    = 64;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int START_BITS        = 32;
    localparam int PREFIX_BITS       = 5;
    localparam int OUT_DATA_BITS     = 40;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_BYTES_LOW      = 2'd1,
        REG_BYTES_HIGH     = 2'd2
    } cfg_reg_e;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic step;     // an item is accepted this cycle
        logic restart;  // that item starts a new text
        logic resync;   // rebuild border bits after a config write
    } cell_ctrl_t;

endpackage

FILE: src/automaton_string_matcher_unit.sv
// Top level of the automaton string matcher: config registers, cell row, output register.
// Depends on amsm_pkg and amsm_cell.
//
// Takes text bytes and returns one result item per byte, at a sustained rate of one
// item per cycle unless m_axis_tready or a config write stalls it. Each cell of a row
// of MAX_PATTERN cells holds one bit: whether the pattern prefix of its length ends
// the text so far; all bits advance together, and the highest set bit is the new
// prefix length. Results leave through a single output register in the cycle after
// the byte is taken. Each config write drops s_axis_tready in the cycle that follows
// it, so a burst of writes holds it low from the cycle after the first write through
// the cycle after the last, while the cells rebuild their bits from the new pattern.
module automaton_string_matcher_unit #(
    parameter int MAX_PATTERN   = amsm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = amsm_pkg::POSITION_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [amsm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [amsm_pkg::BYTES_REG_BITS-1:0]     cfg_data,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [7:0]                              s_axis_tdata,  // [7:0] text_byte
    input  logic                                    s_axis_tuser,  // [0] start_of_text
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [31:0] match_start, [36:32] prefix_length, [39:37] zero
    output logic [amsm_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
    output logic                                    m_axis_tuser   // [0] match_found
);
    import amsm_pkg::*;

    localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
    localparam int CMP_BITS = (LEN_BITS > LENGTH_REG_BITS) ? LEN_BITS : LENGTH_REG_BITS;

    logic [LENGTH_REG_BITS-1:0]     length_reg;
    logic [BYTES_REG_BITS-1:0]      bytes_low_reg;
    logic [BYTES_REG_BITS-1:0]      bytes_high_reg;
    logic                           dirty_reg;
    logic [LEN_BITS-1:0]            state_reg;
    logic [LEN_BITS-1:0]            state_next;
    logic [POSITION_BITS-1:0]       pos_reg;
    logic                           out_valid_reg;
    logic                           found_reg;
    logic [START_BITS-1:0]          start_reg;
    logic [PREFIX_BITS-1:0]         prefix_reg;

    logic [MAX_PATTERN-1:0][7:0]    pattern;
    logic [LEN_BITS-1:0]            eff_length;
    logic [LEN_BITS-1:0]            eff_state;
    logic [MAX_PATTERN-1:0]         hit;
    logic [MAX_PATTERN-1:0]         hit_next;
    logic                           accept;
    logic [POSITION_BITS-1:0]       pos_eff;
    logic [POSITION_BITS-1:0]       start_full;
    logic [63:0]                    start_wide;
    logic                           found;
    cell_ctrl_t                     ctrl;

    // Pattern bytes past the two registers read as zero
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (i < 8)
                pattern[i] = bytes_low_reg[8*i +: 8];
            else if (i < 16)
                pattern[i] = bytes_high_reg[8*(i-8) +: 8];
            else
                pattern[i] = 8'h00;
        end
    end

    always_comb
    begin
        if (length_reg == '0)
            eff_length = LEN_BITS'(1);
        else if (CMP_BITS'(length_reg) > CMP_BITS'(MAX_PATTERN))
            eff_length = LEN_BITS'(MAX_PATTERN);
        else
            eff_length = LEN_BITS'(length_reg);
    end

    assign eff_state = (state_reg > eff_length) ? eff_length : state_reg;

    assign s_axis_tready = !dirty_reg && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ctrl.step    = accept;
    assign ctrl.restart = s_axis_tuser;
    assign ctrl.resync  = dirty_reg;

    generate
        for (genvar g = 0; g < MAX_PATTERN; g++)
        begin : g_cell
            logic prev_hit;
            if (g == 0)
            begin : g_first
                assign prev_hit = 1'b1;
            end
            else
            begin : g_rest
                assign prev_hit = hit[g-1];
            end

            amsm_cell #(
                .MAX_PATTERN (MAX_PATTERN),
                .CELL_INDEX  (g + 1),
                .LEN_BITS    (LEN_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .text_byte  (s_axis_tdata),
                .pattern    (pattern),
                .eff_length (eff_length),
                .eff_state  (eff_state),
                .prev_hit   (prev_hit),
                .hit_next   (hit_next[g]),
                .hit        (hit[g])
            );
        end
    endgenerate

    // Longest matching prefix is the highest set bit of the new row
    always_comb
    begin
        state_next = '0;
        for (int g = 0; g < MAX_PATTERN; g++)
        begin
            if (hit_next[g])
                state_next = LEN_BITS'(g + 1);
        end
    end

    assign pos_eff    = s_axis_tuser ? '0 : pos_reg;
    assign found      = (state_next == eff_length);
    assign start_full = pos_eff - POSITION_BITS'(eff_length) + POSITION_BITS'(1);
    assign start_wide = 64'(start_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg     <= LENGTH_REG_BITS'(1);
            bytes_low_reg  <= '0;
            bytes_high_reg <= '0;
            dirty_reg      <= 1'b0;
        end
        else
        begin
            dirty_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PATTERN_LENGTH: length_reg     <= cfg_data[LENGTH_REG_BITS-1:0];
                    REG_BYTES_LOW:      bytes_low_reg  <= cfg_data;
                    REG_BYTES_HIGH:     bytes_high_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                pos_reg       <= pos_eff + POSITION_BITS'(1);
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg  <= found;
            start_reg  <= found ? start_wide[START_BITS-1:0] : '0;
            prefix_reg <= PREFIX_BITS'(state_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = found_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS - START_BITS - PREFIX_BITS){1'b0}},
                            prefix_reg, start_reg};

endmodule

FILE: src/amsm_cell.sv
// One cell of the matcher row: holds the "prefix of this length is a suffix" bit.
// Depends on amsm_pkg (cell_ctrl_t).
module amsm_cell #(
    parameter int MAX_PATTERN = 16,
    parameter int CELL_INDEX  = 1,
    parameter int LEN_BITS    = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  amsm_pkg::cell_ctrl_t            ctrl,
    input  logic [7:0]                      text_byte,
    input  logic [MAX_PATTERN-1:0][7:0]     pattern,
    input  logic [LEN_BITS-1:0]             eff_length,
    input  logic [LEN_BITS-1:0]             eff_state,
    input  logic                            prev_hit,
    output logic                            hit_next,
    output logic                            hit
);
    import amsm_pkg::*;

    localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_BITS-1:0] LEN_K = LEN_BITS'(CELL_INDEX);

    logic                hit_reg;
    logic                link;
    logic                step_bit;
    logic                border_bit;
    logic [LEN_BITS-1:0] base;
    logic [LEN_BITS-1:0] idx_full;

    // Shift-and step: the neighbor's bit moves up one place if the byte fits
    assign link     = prev_hit && ((CELL_INDEX == 1) || !ctrl.restart);
    assign step_bit = (LEN_K <= eff_length) && (pattern[CELL_INDEX-1] == text_byte) && link;

    // Rebuild: is prefix k a border of prefix eff_state of the current pattern
    always_comb
    begin
        border_bit = (LEN_K <= eff_state);
        base       = eff_state - LEN_K;
        idx_full   = base;
        for (int i = 0; i < CELL_INDEX; i++)
        begin
            idx_full = base + LEN_BITS'(i);
            if (pattern[i] != pattern[IDX_BITS'(idx_full)])
            begin
                border_bit = 1'b0;
            end
        end
    end

    assign hit_next = ctrl.resync ? border_bit : step_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.resync || ctrl.step)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

FILE: src/amsm_checker.sv
// Port-level checks for automaton_string_matcher_unit, bound to the top level.
// Depends on amsm_pkg for port widths.
module amsm_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic                                    s_axis_tvalid,
    input  logic                                    s_axis_tready,
    input  logic                                    s_axis_tuser,
    input  logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic [amsm_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
    input  logic                                    m_axis_tuser
);
    import amsm_pkg::*;

    // Stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result item changed");

    // No match means no start position
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[START_BITS-1:0] == '0)
        else $error("match_start set without a match");

    // A full match always has a nonzero prefix length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[START_BITS +: PREFIX_BITS] != '0)
        else $error("match with empty prefix");

    // Cells rebuild after a config write; no item taken then
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_axis_tready)
        else $error("item accepted during rebuild");

    // First byte of a text can match at most one pattern byte
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=>
            m_axis_tvalid && m_axis_tdata[START_BITS+1 +: PREFIX_BITS-1] == '0)
        else $error("prefix longer than one after restart");

endmodule

bind automaton_string_matcher_unit amsm_checker u_amsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: sim/tb_automaton_string_matcher_unit.sv
// Testbench for automaton_string_matcher_unit: directed and random text streams checked
// item by item against a behavioral prefix-matcher kept inside the bench.
// Depends on amsm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_automaton_string_matcher_unit;
    import amsm_pkg::*;

    localparam int MAX_LEN       = MAX_PATTERN_DEF;
    localparam int RANDOM_ITEMS  = 1630;
    localparam int RANDOM_PHASES = 14;
    localparam int STALL_LIMIT   = 2000;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic        found;
        logic [31:0] start;
        logic [4:0]  prefix;
    } match_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [BYTES_REG_BITS-1:0]   cfg_data = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata = '0;   // [7:0] text_byte
    logic                        s_axis_tuser = 1'b0; // [0] start_of_text
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]    m_axis_tdata;        // [31:0] match_start, [36:32] prefix_length
    logic                        m_axis_tuser;        // [0] match_found

    // matcher copy: registers and state
    logic [4:0]  len_reg;
    logic [63:0] bytes_lo_reg;
    logic [63:0] bytes_hi_reg;
    int          prefix_state;
    logic [31:0] text_pos;

    match_result_t pending_results[$];
    logic [7:0]    pattern_buf[MAX_LEN];

    bit idle_on = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int matches_seen = 0;
    int settings_loaded = 0;

    automaton_string_matcher_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic int effective_len(input logic [4:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_LEN)
            return MAX_LEN;
        return len;
    endfunction

    function automatic logic [7:0] pattern_byte_at(input int i);
        if (i < 8)
            return bytes_lo_reg[8*i +: 8];
        if (i < 16)
            return bytes_hi_reg[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    // Next prefix state and the expected result item for one accepted byte
    task automatic advance_matcher(input logic [7:0] c, input logic sot);
        int eff;
        int s;
        int top;
        int k;
        int idx;
        logic ok;
        logic [7:0] t;
        match_result_t r;
        eff = effective_len(len_reg);
        if (sot)
        begin
            prefix_state = 0;
            text_pos = '0;
        end
        s = (prefix_state > eff) ? eff : prefix_state;
        top = (s + 1 < eff) ? s + 1 : eff;
        k = 0;
        for (int j = top; j >= 1 && k == 0; j--)
        begin
            ok = 1'b1;
            for (int i = 0; i < j; i++)
            begin
                idx = s + 1 - j + i;
                t = (idx == s) ? c : pattern_byte_at(idx);
                if (t != pattern_byte_at(i))
                    ok = 1'b0;
            end
            if (ok)
                k = j;
        end
        r.found = (k == eff);
        r.start = r.found ? text_pos - 32'(eff) + 32'd1 : 32'd0;
        r.prefix = 5'(k);
        pending_results.push_back(r);
        prefix_state = k;
        text_pos = text_pos + 32'd1;
    endtask

    // Called at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_byte(input logic [7:0] b, input logic sot);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= sot;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        advance_matcher(b, sot);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after its last write
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_PATTERN_LENGTH: len_reg = data[4:0];
            REG_BYTES_LOW:      bytes_lo_reg = data;
            REG_BYTES_HIGH:     bytes_hi_reg = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_pattern(input logic [63:0] len, input logic [63:0] lo,
                                input logic [63:0] hi);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, len);
        write_reg(REG_BYTES_LOW, lo);
        write_reg(REG_BYTES_HIGH, hi);
        write_reg(REG_UNMAPPED, {$urandom, $urandom});
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic test_reset_defaults();
        // length 1, pattern byte zero straight out of reset
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_length_zero();
        load_pattern(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b0);
    endtask

    task automatic test_overlap_and_clamp();
        // "aba" gives overlapping hits; junk sits above the used bytes
        load_pattern(64'd3, 64'hFFFF_FFFF_FF61_6261, 64'h0123_4567_89AB_CDEF);
        send_byte(8'h61, 1'b1);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        // shrink to "ab" mid-text: stored state 3 is clamped to 2
        load_pattern(64'd2, 64'hFFFF_FFFF_FF61_6261, 64'h0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        // restart in the middle of a text
        send_byte(8'h61, 1'b1);
        send_byte(8'h62, 1'b0);
    endtask

    task automatic test_random_texts();
        int per_phase;
        int phase_sent;
        int eff;
        int plen;
        int r;
        logic [63:0] len_word;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0] alpha[3];
        logic sot;
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: len_word = 64'd16;
                1: len_word = 64'd31;
                2: len_word = 64'd1;
                3: len_word = 64'd0;
                default: len_word = ($urandom_range(0, 99) < 80) ? 64'($urandom_range(1, 16))
                                                                  : 64'($urandom_range(0, 31));
            endcase
            // upper bits of the length write are ignored by the block
            len_word[63:5] = 59'({$urandom, $urandom} >> 5);
            eff = effective_len(len_word[4:0]);
            for (int a = 0; a < 3; a++)
                alpha[a] = 8'($urandom);
            if (ph % 4 == 0)
                alpha[0] = 8'h00;
            else if (ph % 4 == 1)
                alpha[0] = 8'hFF;
            for (int i = 0; i < MAX_LEN; i++)
                pattern_buf[i] = (i < eff && ph % 5 != 4) ? alpha[$urandom_range(0, 2)]
                                                          : 8'($urandom);
            for (int i = 0; i < 8; i++)
            begin
                lo[8*i +: 8] = pattern_buf[i];
                hi[8*i +: 8] = pattern_buf[i+8];
            end
            load_pattern(len_word, lo, hi);
            idle_on = (ph % 5 != 2);
            phase_sent = 0;
            sot = 1'($urandom_range(0, 1));
            while (phase_sent < per_phase)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    plen = ($urandom_range(0, 99) < 70) ? eff : $urandom_range(1, eff);
                    for (int j = 0; j < plen; j++)
                    begin
                        send_byte(pattern_buf[j], sot);
                        sot = ($urandom_range(0, 99) < 2);
                    end
                    phase_sent += plen;
                end
                else if (r < 85)
                begin
                    plen = $urandom_range(1, 4);
                    for (int j = 0; j < plen; j++)
                    begin
                        send_byte(alpha[$urandom_range(0, 2)], sot);
                        sot = ($urandom_range(0, 99) < 2);
                    end
                    phase_sent += plen;
                end
                else
                begin
                    send_byte(8'($urandom), sot);
                    sot = ($urandom_range(0, 99) < 2);
                    phase_sent++;
                end
            end
        end
    endtask

    // Result side: random stalls on tready
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin : check_result
        match_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no text byte pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.found)
                begin
                    $error("match_found: expected %0d, got %0d", want.found, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[31:0] !== want.start)
                begin
                    $error("match_start: expected %0d, got %0d", want.start,
                           m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[36:32] !== want.prefix)
                begin
                    $error("prefix_length: expected %0d, got %0d", want.prefix,
                           m_axis_tdata[36:32]);
                    fail_count++;
                end
                results_checked++;
                if (want.found)
                    matches_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        len_reg = 5'd1;
        bytes_lo_reg = '0;
        bytes_hi_reg = '0;
        prefix_state = 0;
        text_pos = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_on = 1'b1;

        test_reset_defaults();
        test_length_zero();
        test_overlap_and_clamp();
        test_random_texts();

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Checked %0d results for %0d text bytes over %0d pattern settings,",
                 results_checked, bytes_sent, settings_loaded);
        $display("with %0d full matches among them.", matches_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
src/amsm_pkg.sv
src/amsm_cell.sv
src/automaton_string_matcher_unit.sv
src/amsm_checker.sv
sim/tb_automaton_string_matcher_unit.sv
